>>> rtl/stbs_pkg.sv
// Package for the sorted-table binary search block.
// Holds the request and result types, the action codes and the default depth.
// Used by every file under rtl; depends on nothing.
package stbs_pkg;

  localparam int DEPTH_DEFAULT = 256;
  localparam int VALUE_W       = 32;
  localparam int POSITION_W    = 8;

  localparam logic ACT_LOAD   = 1'b0;
  localparam logic ACT_SEARCH = 1'b1;

  typedef struct packed {
    logic                      action;
    logic signed [VALUE_W-1:0] value;
    logic                      restart;
  } req_t;

  typedef struct packed {
    logic                  found;
    logic [POSITION_W-1:0] position;
  } rsp_t;

endpackage

>>> rtl/sorted_table_binary_search_top.sv
// Top level of the sorted-table binary search block.
// Holds the entry count and the search sequencer; instantiates stbs_table.
// Depends on stbs_pkg for the request and result types.
//
// A request is taken at a rising edge where start is high and busy is low.
// A load request (action = load) writes its value at the next free index,
// or at index 0 when restart is set, at that same edge, and gives no result;
// a load into a full table is dropped unless restart is set. A search request
// gives exactly one result: done is high for one cycle with result.found and
// result.position. Each probe of a search is one read of the table memory,
// whose registered read data is compared in the following cycle while the
// next probe address is issued, so probes follow one another without a gap:
// at most floor(log2(entries)) + 1 probes, with the result registered from
// the last comparison; busy is high from the cycle after acceptance until
// the result. A search on an empty table gives its result in the next cycle
// without becoming busy. The memory read latency sets the probe rate.
// The receiver cannot stall: done is shown for one cycle only, and the next
// request may be taken in that same cycle. Reset empties the table and
// cancels any search in progress; no clearing pass is needed.
module sorted_table_binary_search_top #(
  parameter int DEPTH = stbs_pkg::DEPTH_DEFAULT
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           start,
  input  stbs_pkg::req_t req,
  output logic           busy,
  output logic           done,
  output stbs_pkg::rsp_t result
);

  localparam int AW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);

  typedef enum logic {IDLE, PROBE} state_t;

  state_t                              state;
  logic [CW-1:0]                       count;
  logic [CW-1:0]                       lo;
  logic [CW-1:0]                       hi;
  logic [AW-1:0]                       mid;
  logic signed [stbs_pkg::VALUE_W-1:0] key;

  logic                                accept;
  logic                                wr_en;
  logic [AW-1:0]                       wr_addr;
  logic [CW-1:0]                       count_next;
  logic [stbs_pkg::VALUE_W-1:0]        rd_data;
  logic signed [stbs_pkg::VALUE_W-1:0] probe;
  logic [AW-1:0]                       mid0;
  logic [CW-1:0]                       lo_next;
  logic [CW-1:0]                       hi_next;
  logic [CW-1:0]                       span;
  logic [AW-1:0]                       mid_next;
  logic                                hit;
  logic                                more;
  logic                                rd_en;
  logic [AW-1:0]                       rd_addr;

  assign accept = start && !busy;
  assign busy   = (state == PROBE);

  always_comb begin
    wr_en      = 1'b0;
    wr_addr    = count[AW-1:0];
    count_next = count;
    if (accept && req.action == stbs_pkg::ACT_LOAD) begin
      if (req.restart) begin
        wr_en      = 1'b1;
        wr_addr    = '0;
        count_next = CW'(1);
      end else if (count < CW'(DEPTH)) begin
        wr_en      = 1'b1;
        count_next = count + CW'(1);
      end
    end
  end

  stbs_table #(
    .DEPTH (DEPTH),
    .AW    (AW)
  ) u_table (
    .clk   (clk),
    .we    (wr_en),
    .waddr (wr_addr),
    .wdata (req.value),
    .re    (rd_en),
    .raddr (rd_addr),
    .rdata (rd_data)
  );

  assign probe = $signed(rd_data);
  assign mid0  = AW'((count - CW'(1)) >> 1);
  assign hit   = (probe == key);

  always_comb begin
    lo_next = lo;
    hi_next = hi;
    if (probe < key) begin
      lo_next = CW'(mid) + CW'(1);
    end else begin
      hi_next = CW'(mid);
    end
    span     = hi_next - lo_next - CW'(1);
    mid_next = AW'(lo_next + (span >> 1));
    more     = !hit && (lo_next < hi_next);
  end

  always_comb begin
    rd_en   = 1'b0;
    rd_addr = mid0;
    case (state)
      IDLE: begin
        rd_en   = accept && req.action == stbs_pkg::ACT_SEARCH && count != '0;
        rd_addr = mid0;
      end
      PROBE: begin
        rd_en   = more;
        rd_addr = mid_next;
      end
      default: begin
        rd_en   = 1'b0;
        rd_addr = mid0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= IDLE;
      count <= '0;
      done  <= 1'b0;
    end else begin
      count <= count_next;
      done  <= 1'b0;
      case (state)
        IDLE: begin
          if (accept && req.action == stbs_pkg::ACT_SEARCH) begin
            key <= req.value;
            lo  <= '0;
            hi  <= count;
            mid <= mid0;
            if (count == '0) begin
              done   <= 1'b1;
              result <= '0;
            end else begin
              state <= PROBE;
            end
          end
        end
        PROBE: begin
          lo  <= lo_next;
          hi  <= hi_next;
          mid <= mid_next;
          if (hit) begin
            state           <= IDLE;
            done            <= 1'b1;
            result.found    <= 1'b1;
            result.position <= stbs_pkg::POSITION_W'(mid);
          end else if (!more) begin
            state  <= IDLE;
            done   <= 1'b1;
            result <= '0;
          end
        end
        default: begin
          state <= IDLE;
        end
      endcase
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CW'(DEPTH))
    else $error("entry count exceeds table depth");

  a_probe_range: assert property (@(posedge clk) disable iff (rst)
    state == PROBE |-> (lo < hi) && (CW'(mid) >= lo) && (CW'(mid) < hi))
    else $error("probe index outside the search window");

  a_done_cause: assert property (@(posedge clk) disable iff (rst)
    start && !busy && req.action == stbs_pkg::ACT_LOAD && state == IDLE |=> !done)
    else $error("result given for a load request");

  a_miss_zero: assert property (@(posedge clk) disable iff (rst)
    done && !result.found |-> result.position == '0)
    else $error("position not zero on a miss");

endmodule

>>> rtl/stbs_table.sv
// Table memory of the sorted-table binary search block.
// One write port and one read port; read data is registered.
// Depends on stbs_pkg for the value width.
module stbs_table #(
  parameter int DEPTH = stbs_pkg::DEPTH_DEFAULT,
  parameter int AW    = $clog2(DEPTH)
) (
  input  logic                             clk,
  input  logic                             we,
  input  logic [AW-1:0]                    waddr,
  input  logic [stbs_pkg::VALUE_W-1:0]     wdata,
  input  logic                             re,
  input  logic [AW-1:0]                    raddr,
  output logic [stbs_pkg::VALUE_W-1:0]     rdata
);

  logic [stbs_pkg::VALUE_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule
